### rtl/core/rttb_pkg.sv
package rttb_pkg;

   // bank size: slots are addressed by a 4-bit field, so at most 16 are used
   localparam int SLOTS    = 16;
   localparam int BANK_MAX = 16;
   localparam int BANK     = (SLOTS < BANK_MAX) ? SLOTS : BANK_MAX;

   localparam int SLOT_W = 4;
   localparam int CNT_W  = 5;
   localparam int MS_W   = 20;
   localparam int TICK_W = 16;
   localparam int LEFT_W = 17;
   localparam int DATA_W = 32;

   // ms to ticks: floor(ms / 18) as (ms * ceil(2^24 / 18)) >> 24, exact below 2^21
   localparam int MS_PER_TICK = 18;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + MS_PER_TICK - 1) / MS_PER_TICK;
   localparam int HALF_TICK   = MS_PER_TICK / 2;

   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   localparam logic [1:0] EV_CREATED  = 2'd0;
   localparam logic [1:0] EV_DELETED  = 2'd1;
   localparam logic [1:0] EV_FIRED    = 2'd2;
   localparam logic [1:0] EV_REJECTED = 2'd3;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [SLOT_W-1:0]        slot;
      logic [MS_W-1:0]          delay_ms;
      logic [MS_W-1:0]          repeat_ms;
      logic signed [DATA_W-1:0] user_data;
   } req_type;

   typedef struct packed {
      logic [1:0]               event_kind;
      logic [SLOT_W-1:0]        event_slot;
      logic signed [DATA_W-1:0] event_data;
      logic                     last;
   } rsp_type;

   // one timer record as kept in the record ram
   typedef struct packed {
      logic signed [LEFT_W-1:0] ticks_left;
      logic [TICK_W-1:0]        reload_ticks;
      logic [DATA_W-1:0]        stored_data;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CONV_D,
      ST_CONV_R,
      ST_CREATE,
      ST_WALK
   } state_type;

endpackage

### rtl/core/rttb_ram.sv
module rttb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/rttb_conv.sv
module rttb_conv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rttb_pkg::MS_W-1:0]   ms,
   output logic                       done,
   output logic [rttb_pkg::TICK_W-1:0] ticks
);
   import rttb_pkg::*;

   localparam int PROD_W = 2 * MS_W;

   logic                  stage1_ff, stage1_in;
   logic                  done_ff, done_in;
   logic [MS_W-1:0]       ms1_ff, ms1_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [TICK_W-1:0]     ticks_ff, ticks_in;

   logic [TICK_W-1:0]     quot;
   logic [MS_W-1:0]       quot_wide;
   logic [MS_W-1:0]       rem_wide;
   logic                  round_up;

   // stage 1: reciprocal multiply
   always_comb begin
      stage1_in = start;
      ms1_in    = ms;
      prod_in   = PROD_W'(ms) * PROD_W'(RECIP_MULT);
   end

   // stage 2: remainder and round half to even
   always_comb begin
      quot      = prod_ff[RECIP_SHIFT +: TICK_W];
      quot_wide = MS_W'(quot);
      rem_wide  = ms1_ff - ((quot_wide << 4) + (quot_wide << 1));
      round_up  = (rem_wide > MS_W'(HALF_TICK)) ||
                  ((rem_wide == MS_W'(HALF_TICK)) && quot[0]);
      ticks_in  = quot + TICK_W'(round_up);
      done_in   = stage1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= stage1_in;
         done_ff   <= done_in;
      end
      ms1_ff   <= ms1_in;
      prod_ff  <= prod_in;
      ticks_ff <= ticks_in;
   end

   assign done  = done_ff;
   assign ticks = ticks_ff;

endmodule

### rtl/core/repeating_tick_timer_bank.sv
// bank of up to 16 periodic timers. create (cmd 0) converts delay_ms and
// repeat_ms to ticks of 18 ms (round half to even) in a shared reciprocal
// divider used twice, takes the lowest free slot and appends it to the
// creation-order list, or is rejected when the bank is full. delete (cmd 1)
// answers deleted or rejected. a tick (cmd 2) walks the live timers in
// creation order, one timer a cycle unless a held firing waits on the output,
// through the record ram with its separate read and write ports; it returns
// one fired beat per expiring timer with last on the final one, and no beat
// at all when nothing fires. cmd 3 is taken and ignored. one command at a
// time: req_ready is high only while idle. results leave through an output
// register, so a new command is taken while the last result still waits; a
// stalled rsp_ready stretches the work. no clearing pass after reset.
module repeating_tick_timer_bank (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rttb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rttb_pkg::rsp_type rsp_data
);
   import rttb_pkg::*;

   // control state
   state_type             state_ff, state_in;
   logic [BANK_MAX-1:0]   live_ff, live_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  v2_ff, v2_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  out_valid_ff, out_valid_in;

   // payload state
   req_type               req_ff, req_in;
   logic [SLOT_W-1:0]     order_ff [BANK_MAX];
   logic [SLOT_W-1:0]     order_in [BANK_MAX];
   logic [TICK_W-1:0]     dticks_ff, dticks_in;
   logic [TICK_W-1:0]     rticks_ff, rticks_in;
   logic [SLOT_W-1:0]     s2_ff, s2_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [DATA_W-1:0]     pend_data_ff, pend_data_in;
   rsp_type               out_ff, out_in;

   // conversion unit
   logic                  conv_start;
   logic [MS_W-1:0]       conv_ms;
   logic                  conv_done;
   logic [TICK_W-1:0]     conv_ticks;

   // record ram
   logic                  ram_we;
   logic [SLOT_W-1:0]     ram_waddr;
   rec_type               ram_wdata;
   logic                  ram_re;
   logic [SLOT_W-1:0]     ram_raddr;
   rec_type               ram_rdata;

   // strobes from the output decoder
   logic                  accept;
   logic                  out_free;
   logic                  out_load;
   rsp_type               out_next;
   logic                  do_create;
   logic                  do_delete;
   logic                  walk_issue;
   logic                  walk_retire;
   logic                  walk_flush;

   // derived conditions
   logic                  bank_full;
   logic                  del_ok;
   logic [SLOT_W-1:0]     del_pos;
   logic [SLOT_W-1:0]     free_slot;
   logic                  walk_end;
   logic                  stall;
   logic signed [LEFT_W-1:0] dec_ticks;
   logic                  fire;
   rec_type               upd_rec;

   rttb_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .ms    (conv_ms),
      .done  (conv_done),
      .ticks (conv_ticks)
   );

   rttb_ram #(
      .WIDTH (REC_W),
      .DEPTH (BANK_MAX)
   ) u_rec_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign bank_full = (count_ff >= CNT_W'(BANK));
   assign walk_end  = (idx_ff >= count_ff) && !v2_ff;

   // lowest free slot inside the bank
   always_comb begin
      free_slot = '0;
      for (int j = BANK - 1; j >= 0; j--) begin
         if (!live_ff[j]) begin
            free_slot = SLOT_W'(j);
         end
      end
   end

   // delete check and place of the slot in the creation order
   always_comb begin
      del_ok  = ((SLOT_W + 1)'(req_ff.slot) < (SLOT_W + 1)'(BANK)) && live_ff[req_ff.slot];
      del_pos = '0;
      for (int j = BANK_MAX - 1; j >= 0; j--) begin
         if ((order_ff[j] == req_ff.slot) && (CNT_W'(j) < count_ff)) begin
            del_pos = SLOT_W'(j);
         end
      end
   end

   // walk update of the record last read from the record ram
   always_comb begin
      dec_ticks   = ram_rdata.ticks_left - LEFT_W'(1);
      fire        = dec_ticks[LEFT_W-1] || (dec_ticks == '0);
      upd_rec     = ram_rdata;
      if (fire) begin
         upd_rec.ticks_left = {1'b0, ram_rdata.reload_ticks};
      end else begin
         upd_rec.ticks_left = dec_ticks;
      end
      // a second firing must push the held one out first
      stall = v2_ff && fire && pend_valid_ff && !out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd) inside
                  CMD_CREATE, CMD_DELETE: state_in = ST_EXEC;
                  CMD_TICK:               state_in = ST_WALK;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXEC: begin
            if (req_ff.cmd == CMD_CREATE) begin
               if (!bank_full) begin
                  state_in = ST_CONV_D;
               end else if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CONV_D: begin
            if (conv_done) begin
               state_in = ST_CONV_R;
            end
         end
         ST_CONV_R: begin
            if (conv_done) begin
               state_in = ST_CREATE;
            end
         end
         ST_CREATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (walk_end && (!pend_valid_ff || out_free)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and strobes
   always_comb begin
      req_ready   = 1'b0;
      conv_start  = 1'b0;
      conv_ms     = req_ff.delay_ms;
      out_load    = 1'b0;
      out_next    = '0;
      do_create   = 1'b0;
      do_delete   = 1'b0;
      walk_issue  = 1'b0;
      walk_retire = 1'b0;
      walk_flush  = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = s2_ff;
      ram_wdata   = upd_rec;
      ram_re      = 1'b0;
      ram_raddr   = order_ff[idx_ff[SLOT_W-1:0]];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            if (req_ff.cmd == CMD_CREATE) begin
               if (!bank_full) begin
                  conv_start = 1'b1;
               end else if (out_free) begin
                  out_load            = 1'b1;
                  out_next.event_kind = EV_REJECTED;
                  out_next.last       = 1'b1;
               end
            end else if (out_free) begin
               out_load            = 1'b1;
               do_delete           = del_ok;
               out_next.event_kind = del_ok ? EV_DELETED : EV_REJECTED;
               out_next.event_slot = req_ff.slot;
               out_next.last       = 1'b1;
            end
         end
         ST_CONV_D: begin
            // repeat conversion follows on the same unit
            if (conv_done) begin
               conv_start = 1'b1;
               conv_ms    = req_ff.repeat_ms;
            end
         end
         ST_CONV_R: begin
         end
         ST_CREATE: begin
            if (out_free) begin
               do_create              = 1'b1;
               ram_we                 = 1'b1;
               ram_waddr              = free_slot;
               ram_wdata.ticks_left   = {1'b0, dticks_ff};
               ram_wdata.reload_ticks = rticks_ff;
               ram_wdata.stored_data  = req_ff.user_data;
               out_load               = 1'b1;
               out_next.event_kind    = EV_CREATED;
               out_next.event_slot    = free_slot;
               out_next.last          = 1'b1;
            end
         end
         ST_WALK: begin
            walk_issue  = (idx_ff < count_ff) && !stall;
            ram_re      = walk_issue;
            walk_retire = v2_ff && !stall;
            ram_we      = walk_retire;
            if (walk_retire && fire && pend_valid_ff) begin
               out_load            = 1'b1;
               out_next.event_kind = EV_FIRED;
               out_next.event_slot = pend_slot_ff;
               out_next.event_data = pend_data_ff;
            end
            // held firing is the final beat of this tick
            if (walk_end && pend_valid_ff && out_free) begin
               walk_flush          = 1'b1;
               out_load            = 1'b1;
               out_next.event_kind = EV_FIRED;
               out_next.event_slot = pend_slot_ff;
               out_next.event_data = pend_data_ff;
               out_next.last       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      req_in        = accept ? req_data : req_ff;
      live_in       = live_ff;
      count_in      = count_ff;
      order_in      = order_ff;
      dticks_in     = dticks_ff;
      rticks_in     = rticks_ff;
      idx_in        = idx_ff;
      v2_in         = v2_ff;
      s2_in         = s2_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_data_in  = pend_data_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      if ((state_ff == ST_CONV_D) && conv_done) begin
         dticks_in = conv_ticks;
      end
      if ((state_ff == ST_CONV_R) && conv_done) begin
         rticks_in = conv_ticks;
      end

      if (do_create) begin
         live_in[free_slot]                 = 1'b1;
         order_in[count_ff[SLOT_W-1:0]]     = free_slot;
         count_in                           = count_ff + CNT_W'(1);
      end

      // close the gap left in the creation order
      if (do_delete) begin
         live_in[req_ff.slot] = 1'b0;
         count_in             = count_ff - CNT_W'(1);
         for (int j = 0; j < BANK_MAX - 1; j++) begin
            if (SLOT_W'(j) >= del_pos) begin
               order_in[j] = order_ff[j + 1];
            end
         end
      end

      if (accept) begin
         idx_in        = '0;
         v2_in         = 1'b0;
         pend_valid_in = 1'b0;
      end

      if ((state_ff == ST_WALK) && !stall) begin
         v2_in = walk_issue;
         if (walk_issue) begin
            idx_in = idx_ff + CNT_W'(1);
            s2_in  = ram_raddr;
         end
      end

      if (walk_retire && fire) begin
         pend_valid_in = 1'b1;
         pend_slot_in  = s2_ff;
         pend_data_in  = ram_rdata.stored_data;
      end
      if (walk_flush) begin
         pend_valid_in = 1'b0;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
         out_in       = out_next;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_ff       <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         v2_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         v2_ff         <= v2_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      req_ff       <= req_in;
      order_ff     <= order_in;
      dticks_ff    <= dticks_in;
      rticks_ff    <= rticks_in;
      s2_ff        <= s2_in;
      pend_slot_ff <= pend_slot_in;
      pend_data_ff <= pend_data_in;
      out_ff       <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
